// ===== src/bzs_pkg.sv =====
// ----------------------------------------------------------------------------
// bzs_pkg
// shared constants and types of the cubic bezier segment sampler
// ----------------------------------------------------------------------------
package bzs_pkg;

  localparam int COORD_W       = 32;          // signed q16.16 coordinate
  localparam int T_W           = 16;          // unsigned q0.16 curve parameter
  localparam int FRAC_BITS_DEF = 16;          // weight fraction bits
  localparam int A_W           = 34;          // multiplier a-side width, signed
  localparam int NUM_TERMS     = 4;           // control points per segment
  localparam int NUM_AXES      = 3;           // x, y, z
  localparam int MAX_SAMPLES   = 63;          // curve samples before the closing point

  localparam logic [T_W-1:0] T_STEP_RESET = 16'd4096;
  localparam logic [T_W-1:0] T_STEP_MIN   = 16'd1041;

  // destination of a product leaving the shared multiplier
  typedef enum logic [3:0] {
    D_NONE,
    D_UU,     // u*u
    D_TU3,    // 3*t*u
    D_TT,     // t*t
    D_W0,     // u^3
    D_W1,     // 3*t*u^2
    D_W2,     // 3*t^2*u
    D_W3,     // t^3
    D_MAC     // coordinate times weight
  } dest_t;

  typedef struct packed {
    dest_t       dest;
    logic [1:0]  term;
    logic [1:0]  coord;
  } mul_tag_t;

  typedef struct packed {
    mul_tag_t        issue;
    logic [T_W-1:0]  t;
    logic [T_W:0]    u;
  } seq_ctl_t;

endpackage

// ===== src/bzs_seg_if.sv =====
// ----------------------------------------------------------------------------
// bzs_seg_if
// segment channel: four 3-d control points per beat
// ----------------------------------------------------------------------------
interface bzs_seg_if;

  logic                                valid;
  logic                                ready;
  logic signed [bzs_pkg::COORD_W-1:0]  p0_x;
  logic signed [bzs_pkg::COORD_W-1:0]  p0_y;
  logic signed [bzs_pkg::COORD_W-1:0]  p0_z;
  logic signed [bzs_pkg::COORD_W-1:0]  p1_x;
  logic signed [bzs_pkg::COORD_W-1:0]  p1_y;
  logic signed [bzs_pkg::COORD_W-1:0]  p1_z;
  logic signed [bzs_pkg::COORD_W-1:0]  p2_x;
  logic signed [bzs_pkg::COORD_W-1:0]  p2_y;
  logic signed [bzs_pkg::COORD_W-1:0]  p2_z;
  logic signed [bzs_pkg::COORD_W-1:0]  p3_x;
  logic signed [bzs_pkg::COORD_W-1:0]  p3_y;
  logic signed [bzs_pkg::COORD_W-1:0]  p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
           p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );

  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
           p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );

endinterface

// ===== src/bzs_pnt_if.sv =====
// ----------------------------------------------------------------------------
// bzs_pnt_if
// point channel: one sampled curve point per beat
// ----------------------------------------------------------------------------
interface bzs_pnt_if;

  logic                                valid;
  logic                                ready;
  logic signed [bzs_pkg::COORD_W-1:0]  out_x;
  logic signed [bzs_pkg::COORD_W-1:0]  out_y;
  logic signed [bzs_pkg::COORD_W-1:0]  out_z;
  logic                                is_last;

  modport source (
    output valid, out_x, out_y, out_z, is_last,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, is_last,
    output ready
  );

endinterface

// ===== src/bzs_mul.sv =====
// ----------------------------------------------------------------------------
// bzs_mul
// shared signed multiplier, registered product with its destination tag
// ----------------------------------------------------------------------------
module bzs_mul #(
  parameter int A_W = 34,
  parameter int B_W = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [A_W-1:0]     a,
  input  logic signed [B_W-1:0]     b,
  input  bzs_pkg::mul_tag_t         tag_in,
  output logic signed [A_W+B_W-1:0] prod,
  output bzs_pkg::mul_tag_t         tag_out
);

  import bzs_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '{dest: D_NONE, term: 2'd0, coord: 2'd0};
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

// ===== src/bzs_seq.sv =====
// ----------------------------------------------------------------------------
// bzs_seq
// sequencer: step register, parameter walk, multiplier op issue, handshakes
// ----------------------------------------------------------------------------
module bzs_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bzs_pkg::T_W-1:0]  cfg_wdata,
  input  logic                     seg_valid,
  output logic                     seg_ready,
  output logic                     pnt_valid,
  input  logic                     pnt_ready,
  output logic                     pnt_last,
  output bzs_pkg::seq_ctl_t        ctl
);

  import bzs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WEIGHT,
    S_MAC,
    S_DRAIN,
    S_EMIT,
    S_LAST
  } state_t;

  localparam logic [2:0] WOP_LAST  = 3'd6;
  localparam logic [1:0] TERM_LAST = 2'(NUM_TERMS - 1);
  localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);
  localparam logic [5:0] SAMP_LAST = 6'(MAX_SAMPLES - 1);

  state_t          state;
  logic [T_W-1:0]  t_step;
  logic [T_W-1:0]  step;
  logic [T_W:0]    t;
  logic [T_W:0]    t_next;
  logic [5:0]      nsamp;
  logic [2:0]      wop;
  logic [1:0]      term;
  logic [1:0]      coord;
  dest_t           wdest;

  // a step below the minimum is raised to it
  assign step   = (t_step < T_STEP_MIN) ? T_STEP_MIN : t_step;
  assign t_next = t + {1'b0, step};

  assign seg_ready = (state == S_IDLE);

  always_comb begin
    case (wop)
      3'd0:    wdest = D_UU;
      3'd1:    wdest = D_TU3;
      3'd2:    wdest = D_TT;
      3'd3:    wdest = D_W0;
      3'd4:    wdest = D_W1;
      3'd5:    wdest = D_W2;
      3'd6:    wdest = D_W3;
      default: wdest = D_NONE;
    endcase
  end

  always_comb begin
    ctl.t           = t[T_W-1:0];
    ctl.u           = {1'b1, {T_W{1'b0}}} - {1'b0, t[T_W-1:0]};
    ctl.issue.term  = term;
    ctl.issue.coord = coord;
    case (state)
      S_WEIGHT: ctl.issue.dest = wdest;
      S_MAC:    ctl.issue.dest = D_MAC;
      default:  ctl.issue.dest = D_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      t_step    <= T_STEP_RESET;
      t         <= '0;
      nsamp     <= '0;
      wop       <= '0;
      term      <= '0;
      coord     <= '0;
      pnt_valid <= 1'b0;
      pnt_last  <= 1'b0;
    end else begin
      if (cfg_we) begin
        t_step <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (seg_valid) begin
            t     <= '0;
            nsamp <= '0;
            wop   <= '0;
            state <= S_WEIGHT;
          end
        end
        S_WEIGHT: begin
          if (wop == WOP_LAST) begin
            term  <= '0;
            coord <= '0;
            state <= S_MAC;
          end else begin
            wop <= wop + 3'd1;
          end
        end
        S_MAC: begin
          term <= term + 2'd1;
          if (term == TERM_LAST) begin
            if (coord == AXIS_LAST) begin
              state <= S_DRAIN;
            end else begin
              coord <= coord + 2'd1;
            end
          end
        end
        S_DRAIN: begin
          pnt_valid <= 1'b1;
          pnt_last  <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (pnt_ready) begin
            nsamp <= nsamp + 6'd1;
            if (t_next[T_W] || nsamp == SAMP_LAST) begin
              pnt_last <= 1'b1;
              state    <= S_LAST;
            end else begin
              pnt_valid <= 1'b0;
              t         <= t_next;
              wop       <= '0;
              state     <= S_WEIGHT;
            end
          end
        end
        S_LAST: begin
          if (pnt_ready) begin
            pnt_valid <= 1'b0;
            pnt_last  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/cubic_bezier_segment_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_segment_sampler_unit
// Takes one cubic bezier segment (four signed q16.16 control points) per
// beat on seg and emits on pnt the curve points B(t) for t = 0, step,
// 2*step, ... while t < 1, then p3 exactly with is_last set. t_step is an
// unsigned q0.16 increment written through cfg_we/cfg_wdata (reset 4096,
// values below 1041 act as 1041), so a segment yields at most 63 samples
// plus the closing point. Bernstein weights are rounded half up to
// FRAC_BITS fraction bits and each coordinate sum is rounded half up to
// q16.16 and saturated. One signed multiplier is shared by all the work:
// seven products build the four weights and twelve multiply-accumulates
// build x, y and z. Each sample then passes a drain state and waits in
// an output state until the sink takes it, and the closing point follows
// the last sample. seg is ready only while the block is idle.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_sampler_unit #(
  parameter int FRAC_BITS = bzs_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bzs_pkg::T_W-1:0]  cfg_wdata,
  bzs_seg_if.sink                  seg,
  bzs_pnt_if.source                pnt
);

  import bzs_pkg::*;

  // multiplier b side carries t/u (17 bits) or a weight (FRAC_BITS+1 bits)
  localparam int B_W   = (FRAC_BITS + 2 > T_W + 2) ? FRAC_BITS + 2 : T_W + 2;
  localparam int P_W   = A_W + B_W;
  localparam int W_W   = FRAC_BITS + 1;
  // four products of coordinate times weight plus rounding bias
  localparam int ACC_W = COORD_W + FRAC_BITS + 3;

  // half an lsb of the rounded weight in the exact q0.48 product
  localparam logic signed [P_W-1:0] W_HALF =
    {{(P_W - 48 + FRAC_BITS){1'b0}}, 1'b1, {(47 - FRAC_BITS){1'b0}}};
  // half an lsb of q16.16 in the q16.(16+FRAC_BITS) sum
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  seq_ctl_t                      ctl;
  mul_tag_t                      mtag;
  logic signed [A_W-1:0]         a_op;
  logic signed [B_W-1:0]         b_op;
  logic signed [P_W-1:0]         prod;
  logic                          pnt_last;

  // captured control points, [point][axis]
  logic signed [COORD_W-1:0]     pts [NUM_TERMS][NUM_AXES];

  // intermediates of the weight build
  logic [T_W+T_W:0]              uu;     // u*u, up to 2^32
  logic [T_W+T_W-1:0]            tu3;    // 3*t*u
  logic [T_W+T_W-1:0]            tt;     // t*t
  logic [W_W-1:0]                wgt [NUM_TERMS];

  logic signed [ACC_W-1:0]       acc;
  logic signed [COORD_W-1:0]     res [NUM_AXES];

  logic signed [P_W-1:0]         wsum;
  logic signed [ACC_W-1:0]       prod_a;
  logic signed [ACC_W-1:0]       sum;
  logic signed [ACC_W-1:0]       q;
  logic                          q_fits;
  logic signed [COORD_W-1:0]     q_sat;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  bzs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .seg_valid (seg.valid),
    .seg_ready (seg.ready),
    .pnt_valid (pnt.valid),
    .pnt_ready (pnt.ready),
    .pnt_last  (pnt_last),
    .ctl       (ctl)
  );

  // --------------------------------------------------------------------------
  // operand select for the shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    case (ctl.issue.dest)
      D_UU: begin
        a_op = {{(A_W - T_W - 1){1'b0}}, ctl.u};
        b_op = {{(B_W - T_W - 1){1'b0}}, ctl.u};
      end
      D_TU3: begin
        a_op = {{(A_W - T_W){1'b0}}, ctl.t};
        b_op = {{(B_W - T_W - 1){1'b0}}, ctl.u};
      end
      D_TT: begin
        a_op = {{(A_W - T_W){1'b0}}, ctl.t};
        b_op = {{(B_W - T_W){1'b0}}, ctl.t};
      end
      D_W0: begin
        a_op = {{(A_W - 2 * T_W - 1){1'b0}}, uu};
        b_op = {{(B_W - T_W - 1){1'b0}}, ctl.u};
      end
      D_W1: begin
        a_op = {{(A_W - 2 * T_W){1'b0}}, tu3};
        b_op = {{(B_W - T_W - 1){1'b0}}, ctl.u};
      end
      D_W2: begin
        a_op = {{(A_W - 2 * T_W){1'b0}}, tu3};
        b_op = {{(B_W - T_W){1'b0}}, ctl.t};
      end
      D_W3: begin
        a_op = {{(A_W - 2 * T_W){1'b0}}, tt};
        b_op = {{(B_W - T_W){1'b0}}, ctl.t};
      end
      D_MAC: begin
        a_op = {{(A_W - COORD_W){pts[ctl.issue.term][ctl.issue.coord][COORD_W-1]}},
                pts[ctl.issue.term][ctl.issue.coord]};
        b_op = {{(B_W - W_W){1'b0}}, wgt[ctl.issue.term]};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  bzs_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (a_op),
    .b       (b_op),
    .tag_in  (ctl.issue),
    .prod    (prod),
    .tag_out (mtag)
  );

  // --------------------------------------------------------------------------
  // write-back of the registered product
  // --------------------------------------------------------------------------
  // weight rounding: half up from q0.48 to q0.FRAC_BITS
  assign wsum   = prod + W_HALF;
  // coordinate products fit well inside the accumulator
  assign prod_a = prod[ACC_W-1:0];
  assign sum    = acc + prod_a;
  assign q      = sum >>> FRAC_BITS;
  // fits in 32 bits when every bit above bit 30 matches the sign
  assign q_fits = (q[ACC_W-1:COORD_W-1] == '0) || (q[ACC_W-1:COORD_W-1] == '1);
  assign q_sat  = q_fits ? q[COORD_W-1:0]
                         : {q[ACC_W-1], {(COORD_W - 1){~q[ACC_W-1]}}};

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      pts[0][0] <= seg.p0_x;
      pts[0][1] <= seg.p0_y;
      pts[0][2] <= seg.p0_z;
      pts[1][0] <= seg.p1_x;
      pts[1][1] <= seg.p1_y;
      pts[1][2] <= seg.p1_z;
      pts[2][0] <= seg.p2_x;
      pts[2][1] <= seg.p2_y;
      pts[2][2] <= seg.p2_z;
      pts[3][0] <= seg.p3_x;
      pts[3][1] <= seg.p3_y;
      pts[3][2] <= seg.p3_z;
    end
    case (mtag.dest)
      D_UU:  uu     <= prod[2 * T_W:0];
      // 3*t*u stays below 2^32
      D_TU3: tu3    <= prod[2 * T_W - 1:0] + {prod[2 * T_W - 2:0], 1'b0};
      D_TT:  tt     <= prod[2 * T_W - 1:0];
      D_W0:  wgt[0] <= wsum[48:48 - FRAC_BITS];
      D_W1:  wgt[1] <= wsum[48:48 - FRAC_BITS];
      D_W2:  wgt[2] <= wsum[48:48 - FRAC_BITS];
      D_W3:  wgt[3] <= wsum[48:48 - FRAC_BITS];
      D_MAC: begin
        case (mtag.term)
          2'd0:    acc <= ACC_HALF + prod_a;
          2'd3:    res[mtag.coord] <= q_sat;
          default: acc <= sum;
        endcase
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output beat: sampled point, or p3 untouched on the closing beat
  // --------------------------------------------------------------------------
  assign pnt.out_x   = pnt_last ? pts[3][0] : res[0];
  assign pnt.out_y   = pnt_last ? pts[3][1] : res[1];
  assign pnt.out_z   = pnt_last ? pts[3][2] : res[2];
  assign pnt.is_last = pnt_last;

`ifndef SYNTH
  // never taking a segment while a point is on offer
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(seg.ready && pnt.valid))
    else $error("segment accepted while a point beat is pending");

  // closing beat taken returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (pnt.valid && pnt.ready && pnt.is_last) |=> (seg.ready && !pnt.valid))
    else $error("block not idle after closing beat");

  // a new segment starts with the weight build, no point right away
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> (!pnt.valid && !seg.ready))
    else $error("point offered or ready held right after segment accept");
`endif

endmodule
